// ===== src/tuvw_pkg.sv =====
// ----------------------------------------------------------------------------
// tuvw_pkg
// Shared constants, types and latency figures for the triplanar block.
// ----------------------------------------------------------------------------
`default_nettype none

package tuvw_pkg;

  localparam int SHARP_W          = 5;
  localparam int DEF_MAX_SHARPNESS = 16;
  localparam int OUT_W            = 17;
  localparam logic [OUT_W-1:0] ONE_Q16  = 17'd65536;
  localparam logic [OUT_W-1:0] HALF_Q16 = 17'd32768;

  // quotient widths of the four divider pipelines
  localparam int RDIV_Q = 17;  // relative extent
  localparam int CDIV_Q = 17;  // coordinate
  localparam int QDIV_Q = 31;  // normalized normal component, Q1.30
  localparam int WDIV_Q = 17;  // final weight

  localparam int COORD_LATENCY = 2 + RDIV_Q + 2 + CDIV_Q + 1;

  function automatic int weight_latency(int max_sharp);
    return 2 + QDIV_Q + (max_sharp - 1) + 2 + WDIV_Q + 1;
  endfunction

  typedef struct packed {
    logic [2:0][OUT_W-1:0] coord;
    logic                  zbox;
  } coord_res_t;

  typedef struct packed {
    logic [2:0][OUT_W-1:0] weight;
    logic                  znorm;
  } weight_res_t;

  function automatic logic [31:0] absdiff(input logic signed [31:0] a,
                                          input logic signed [31:0] b);
    logic signed [32:0] t;
    t = 33'(a) - 33'(b);
    return t[32] ? 32'(-t) : t[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/tuvw_div.sv =====
// ----------------------------------------------------------------------------
// tuvw_div
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one valid, with a sideband carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module tuvw_div #(
  parameter int Lanes     = 3,
  parameter int DividendW = 48,
  parameter int DivisorW  = 32,
  parameter int QuotW     = 17,
  parameter int SideW     = 1
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                valid_i,
  input  wire logic [Lanes-1:0][DividendW-1:0]     dividend_i,
  input  wire logic [Lanes-1:0][DivisorW-1:0]      divisor_i,
  input  wire logic [SideW-1:0]                    side_i,
  output logic                                     valid_o,
  output logic      [Lanes-1:0][QuotW-1:0]         quot_o,
  output logic      [SideW-1:0]                    side_o
);

  logic                           vld_q  [QuotW];
  logic [Lanes-1:0][DivisorW-1:0] rem_q  [QuotW];
  logic [Lanes-1:0][QuotW-1:0]    word_q [QuotW];
  logic [Lanes-1:0][DivisorW-1:0] dvs_q  [QuotW];
  logic [SideW-1:0]               side_q [QuotW];

  for (genvar k = 0; k < QuotW; k++) begin : g_step
    logic                           v_in;
    logic [Lanes-1:0][DivisorW-1:0] r_in;
    logic [Lanes-1:0][DivisorW-1:0] y_in;
    logic [Lanes-1:0][QuotW-1:0]    w_in;
    logic [SideW-1:0]               s_in;
    logic [Lanes-1:0][DivisorW:0]   trial;
    logic [Lanes-1:0][DivisorW-1:0] rem_d;
    logic [Lanes-1:0][QuotW-1:0]    word_d;

    if (k == 0) begin : g_load
      logic [Lanes-1:0][DividendW+DivisorW-1:0] xext;
      // upper dividend bits form the first partial remainder
      always_comb begin
        for (int l = 0; l < Lanes; l++) begin
          xext[l] = {{DivisorW{1'b0}}, dividend_i[l]};
          r_in[l] = xext[l][QuotW+DivisorW-1:QuotW];
          w_in[l] = dividend_i[l][QuotW-1:0];
        end
      end
      assign v_in = valid_i;
      assign y_in = divisor_i;
      assign s_in = side_i;
    end else begin : g_chain
      assign v_in = vld_q[k-1];
      assign r_in = rem_q[k-1];
      assign w_in = word_q[k-1];
      assign y_in = dvs_q[k-1];
      assign s_in = side_q[k-1];
    end

    always_comb begin
      for (int l = 0; l < Lanes; l++) begin
        trial[l] = {r_in[l], w_in[l][QuotW-1]};
        if (trial[l] >= {1'b0, y_in[l]}) begin
          rem_d[l]  = DivisorW'(trial[l] - {1'b0, y_in[l]});
          word_d[l] = {w_in[l][QuotW-2:0], 1'b1};
        end else begin
          rem_d[l]  = trial[l][DivisorW-1:0];
          word_d[l] = {w_in[l][QuotW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= rem_d;
      word_q[k] <= word_d;
      dvs_q[k]  <= y_in;
      side_q[k] <= s_in;
    end
  end

  assign valid_o = vld_q[QuotW-1];
  assign quot_o  = word_q[QuotW-1];
  assign side_o  = side_q[QuotW-1];

endmodule

`default_nettype wire

// ===== src/tuvw_delay.sv =====
// ----------------------------------------------------------------------------
// tuvw_delay
// Fixed-depth shift line with valid, lines up the coordinate results with
// the longer weight pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module tuvw_delay #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  valid_o,
  output logic      [Width-1:0] data_o
);

  logic             vld_q  [Depth];
  logic [Width-1:0] data_q [Depth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < Depth; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    data_q[0] <= data_i;
    for (int i = 1; i < Depth; i++) data_q[i] <= data_q[i-1];
  end

  assign valid_o = vld_q[Depth-1];
  assign data_o  = data_q[Depth-1];

endmodule

`default_nettype wire

// ===== src/tuvw_coord.sv =====
// ----------------------------------------------------------------------------
// tuvw_coord
// Coordinate pipeline: extents, largest extent, relative extent divider,
// scaled offset, coordinate divider and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module tuvw_coord import tuvw_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    valid_i,
  input  wire logic [2:0][31:0]        lo_i,
  input  wire logic [2:0][31:0]        hi_i,
  input  wire logic [2:0][31:0]        pt_i,
  output logic                         valid_o,
  output coord_res_t                   res_o
);

  typedef struct packed {
    logic [2:0][31:0] d;
    logic [2:0][31:0] e;
    logic             zb;
  } rside_t;

  typedef struct packed {
    logic [2:0][15:0] c;
    logic [2:0]       ovf;
    logic [2:0]       zd;
    logic             zb;
  } cside_t;

  // stage 1: extents and point offsets
  logic             v1_q;
  logic [2:0][31:0] d1_q, e1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      d1_q[i] <= absdiff(hi_i[i], lo_i[i]);
      e1_q[i] <= absdiff(pt_i[i], lo_i[i]);
    end
  end

  // stage 2: largest extent
  logic        v2_q;
  logic [31:0] t2_q, tmax_d;
  rside_t      rs2_q;

  always_comb begin
    tmax_d = d1_q[0];
    if (d1_q[1] > tmax_d) tmax_d = d1_q[1];
    if (d1_q[2] > tmax_d) tmax_d = d1_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    t2_q     <= tmax_d;
    rs2_q.d  <= d1_q;
    rs2_q.e  <= e1_q;
    rs2_q.zb <= (tmax_d == '0);
  end

  // relative extent r = d * 65536 / T
  logic [2:0][47:0] rnum;
  logic [2:0][31:0] rden;
  logic             rv;
  logic [2:0][RDIV_Q-1:0] rq;
  rside_t           rs;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnum[i] = {rs2_q.d[i], 16'd0};
      rden[i] = t2_q;
    end
  end

  tuvw_div #(
    .Lanes(3), .DividendW(48), .DivisorW(32), .QuotW(RDIV_Q), .SideW($bits(rside_t))
  ) u_rdiv (
    .clk_i, .rst_ni,
    .valid_i(v2_q), .dividend_i(rnum), .divisor_i(rden), .side_i(rs2_q),
    .valid_o(rv), .quot_o(rq), .side_o(rs)
  );

  // stage 3: offset times relative extent, centering constant
  logic             v3_q;
  logic [2:0][48:0] p3_q;
  logic [2:0][15:0] c3_q;
  logic [2:0][31:0] d3_q;
  logic             zb3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= rv;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      p3_q[i] <= 49'(rs.e[i]) * 49'(rq[i]);
      c3_q[i] <= 16'((ONE_Q16 - rq[i]) >> 1);
    end
    d3_q  <= rs.d;
    zb3_q <= rs.zb;
  end

  // stage 4: quotient would pass 17 bits, so it saturates anyway
  logic             v4_q;
  logic [2:0][48:0] x4_q;
  logic [2:0][31:0] d4_q;
  cside_t           cs4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else         v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      cs4_q.ovf[i] <= (p3_q[i][48:17] >= d3_q[i]);
      cs4_q.zd[i]  <= (d3_q[i] == '0);
      x4_q[i]      <= (p3_q[i][48:17] >= d3_q[i]) ? '0 : p3_q[i];
    end
    cs4_q.c  <= c3_q;
    cs4_q.zb <= zb3_q;
    d4_q     <= d3_q;
  end

  logic             cv;
  logic [2:0][CDIV_Q-1:0] cq;
  cside_t           cs;

  tuvw_div #(
    .Lanes(3), .DividendW(49), .DivisorW(32), .QuotW(CDIV_Q), .SideW($bits(cside_t))
  ) u_cdiv (
    .clk_i, .rst_ni,
    .valid_i(v4_q), .dividend_i(x4_q), .divisor_i(d4_q), .side_i(cs4_q),
    .valid_o(cv), .quot_o(cq), .side_o(cs)
  );

  // stage 5: add center, saturate, special cases
  logic       v5_q;
  coord_res_t res_q;
  logic [2:0][17:0] sum;

  always_comb begin
    for (int i = 0; i < 3; i++) sum[i] = 18'(cq[i]) + 18'(cs.c[i]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else         v5_q <= cv;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (cs.zb)                      res_q.coord[i] <= HALF_Q16;
      else if (cs.zd[i])              res_q.coord[i] <= 17'(cs.c[i]);
      else if (cs.ovf[i])             res_q.coord[i] <= ONE_Q16;
      else if (sum[i] > 18'(ONE_Q16)) res_q.coord[i] <= ONE_Q16;
      else                            res_q.coord[i] <= sum[i][16:0];
    end
    res_q.zbox <= cs.zb;
  end

  assign valid_o = v5_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

// ===== src/tuvw_weight.sv =====
// ----------------------------------------------------------------------------
// tuvw_weight
// Blend weight pipeline: |n|, normalization by the largest component,
// power stages, sum and final normalizing divider.
// ----------------------------------------------------------------------------
`default_nettype none

module tuvw_weight import tuvw_pkg::*; #(
  parameter int MaxSharpness = DEF_MAX_SHARPNESS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire logic [2:0][15:0]   normal_i,
  input  wire logic [SHARP_W-1:0] sharp_i,
  output logic                    valid_o,
  output weight_res_t             res_o
);

  localparam int PowStages = MaxSharpness - 1;

  typedef struct packed {
    logic               zn;
    logic [SHARP_W-1:0] s;
  } qside_t;

  // stage 1: magnitudes, clamped exponent
  logic               v1_q;
  logic [2:0][15:0]   a1_q;
  logic [SHARP_W-1:0] s1_q, s_d;

  always_comb begin
    if (sharp_i == '0)                             s_d = SHARP_W'(1);
    else if (32'(sharp_i) > 32'(MaxSharpness))     s_d = SHARP_W'(MaxSharpness);
    else                                           s_d = sharp_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      a1_q[i] <= normal_i[i][15] ? 16'(-normal_i[i]) : normal_i[i];
    end
    s1_q <= s_d;
  end

  // stage 2: largest component, dividend a*2^30 + m/2
  logic             v2_q;
  logic [2:0][45:0] x2_q;
  logic [2:0][15:0] m2_q;
  qside_t           qs2_q;
  logic [15:0]      m_d;

  always_comb begin
    m_d = a1_q[0];
    if (a1_q[1] > m_d) m_d = a1_q[1];
    if (a1_q[2] > m_d) m_d = a1_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      // low 30 bits of a<<30 are zero, so the rounding half just fills them
      x2_q[i] <= {a1_q[i], 15'd0, m_d[15:1]};
      m2_q[i] <= m_d;
    end
    qs2_q.zn <= (m_d == '0);
    qs2_q.s  <= s1_q;
  end

  logic             qv;
  logic [2:0][QDIV_Q-1:0] qq;
  qside_t           qs;

  tuvw_div #(
    .Lanes(3), .DividendW(46), .DivisorW(16), .QuotW(QDIV_Q), .SideW($bits(qside_t))
  ) u_qdiv (
    .clk_i, .rst_ni,
    .valid_i(v2_q), .dividend_i(x2_q), .divisor_i(m2_q), .side_i(qs2_q),
    .valid_o(qv), .quot_o(qq), .side_o(qs)
  );

  // power stages: stage j multiplies once more while j < sharpness
  logic                   pv_q   [PowStages+1];
  logic [2:0][QDIV_Q-1:0] base_q [PowStages+1];
  logic [2:0][QDIV_Q-1:0] acc_q  [PowStages+1];
  qside_t                 ps_q   [PowStages+1];

  assign pv_q[0]   = qv;
  assign base_q[0] = qq;
  assign acc_q[0]  = qq;
  assign ps_q[0]   = qs;

  for (genvar j = 1; j <= PowStages; j++) begin : g_pow
    logic [2:0][61:0] prod;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        prod[i] = 62'(acc_q[j-1][i]) * 62'(base_q[j-1][i]) + 62'(1 << 29);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) pv_q[j] <= 1'b0;
      else         pv_q[j] <= pv_q[j-1];
    end

    always_ff @(posedge clk_i) begin
      for (int i = 0; i < 3; i++) begin
        if (32'(ps_q[j-1].s) > 32'(j)) acc_q[j][i] <= prod[i][60:30];
        else                           acc_q[j][i] <= acc_q[j-1][i];
      end
      base_q[j] <= base_q[j-1];
      ps_q[j]   <= ps_q[j-1];
    end
  end

  // sum of powers
  logic                   vs_q;
  logic [31:0]            sum_q;
  logic [2:0][QDIV_Q-1:0] pw_q;
  logic                   zns_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vs_q <= 1'b0;
    else         vs_q <= pv_q[PowStages];
  end

  always_ff @(posedge clk_i) begin
    sum_q <= 32'(acc_q[PowStages][0]) + 32'(acc_q[PowStages][1])
           + 32'(acc_q[PowStages][2]);
    pw_q  <= acc_q[PowStages];
    zns_q <= ps_q[PowStages].zn;
  end

  // rounding dividend q*65536 + S/2
  logic             vx_q;
  logic [2:0][46:0] wx_q;
  logic [2:0][31:0] wd_q;
  logic             znx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vx_q <= 1'b0;
    else         vx_q <= vs_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      wx_q[i] <= {pw_q[i], 16'd0} + 47'(sum_q >> 1);
      wd_q[i] <= sum_q;
    end
    znx_q <= zns_q;
  end

  logic             wv;
  logic [2:0][WDIV_Q-1:0] wq;
  logic             wzn;

  tuvw_div #(
    .Lanes(3), .DividendW(47), .DivisorW(32), .QuotW(WDIV_Q), .SideW(1)
  ) u_wdiv (
    .clk_i, .rst_ni,
    .valid_i(vx_q), .dividend_i(wx_q), .divisor_i(wd_q), .side_i(znx_q),
    .valid_o(wv), .quot_o(wq), .side_o(wzn)
  );

  logic        vo_q;
  weight_res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else         vo_q <= wv;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) res_q.weight[i] <= wzn ? '0 : wq[i];
    res_q.znorm <= wzn;
  end

  assign valid_o = vo_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

// ===== src/triplanar_uv_and_weights.sv =====
// ----------------------------------------------------------------------------
// triplanar_uv_and_weights
// Triplanar projection coordinates and blend weights for one shading point.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  input     start & !busy              box_min/max xyz, point xyz, normal xyz
//  result    done (one-cycle strobe)    six plane coordinates, three weights,
//                                       status
//  config    cfg_valid & cfg_ready      sharpness (5 bits)
//
//  One transaction enters per cycle; busy never rises.
//  The weight path is the longer one: a 31-stage normalizing divider,
//  MAX_SHARPNESS-1 multiply stages and a 17-stage weight divider.
//  Coordinates come through a shorter path and are delayed.
//  Reset clears all valid bits and sets sharpness to 1; results in flight
//  are dropped. The receiver cannot stall, so the pipeline never stops.
// ----------------------------------------------------------------------------
`default_nettype none

module triplanar_uv_and_weights import tuvw_pkg::*; #(
  parameter int MAX_SHARPNESS = DEF_MAX_SHARPNESS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [31:0]        box_min_x_i,
  input  wire logic [31:0]        box_min_y_i,
  input  wire logic [31:0]        box_min_z_i,
  input  wire logic [31:0]        box_max_x_i,
  input  wire logic [31:0]        box_max_y_i,
  input  wire logic [31:0]        box_max_z_i,
  input  wire logic [31:0]        point_x_i,
  input  wire logic [31:0]        point_y_i,
  input  wire logic [31:0]        point_z_i,
  input  wire logic [15:0]        normal_x_i,
  input  wire logic [15:0]        normal_y_i,
  input  wire logic [15:0]        normal_z_i,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [SHARP_W-1:0] cfg_data_i,
  output logic                    done_o,
  output logic [OUT_W-1:0]        xy_u_o,
  output logic [OUT_W-1:0]        xy_v_o,
  output logic [OUT_W-1:0]        xz_u_o,
  output logic [OUT_W-1:0]        xz_v_o,
  output logic [OUT_W-1:0]        yz_u_o,
  output logic [OUT_W-1:0]        yz_v_o,
  output logic [OUT_W-1:0]        weight_xy_o,
  output logic [OUT_W-1:0]        weight_xz_o,
  output logic [OUT_W-1:0]        weight_yz_o,
  output logic [1:0]              status_o
);

  localparam int AlignDepth = weight_latency(MAX_SHARPNESS) - COORD_LATENCY;

  logic               accept;
  logic [SHARP_W-1:0] sharpness_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sharpness_q <= SHARP_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      sharpness_q <= cfg_data_i;
    end
  end

  logic        cv, cdv, wv;
  coord_res_t  cres, cdres;
  weight_res_t wres;

  tuvw_coord u_coord (
    .clk_i, .rst_ni,
    .valid_i(accept),
    .lo_i({box_min_z_i, box_min_y_i, box_min_x_i}),
    .hi_i({box_max_z_i, box_max_y_i, box_max_x_i}),
    .pt_i({point_z_i, point_y_i, point_x_i}),
    .valid_o(cv),
    .res_o(cres)
  );

  tuvw_delay #(
    .Width($bits(coord_res_t)), .Depth(AlignDepth)
  ) u_align (
    .clk_i, .rst_ni,
    .valid_i(cv), .data_i(cres),
    .valid_o(cdv), .data_o(cdres)
  );

  tuvw_weight #(
    .MaxSharpness(MAX_SHARPNESS)
  ) u_weight (
    .clk_i, .rst_ni,
    .valid_i(accept),
    .normal_i({normal_z_i, normal_y_i, normal_x_i}),
    .sharp_i(sharpness_q),
    .valid_o(wv),
    .res_o(wres)
  );

  assign done_o      = wv & cdv;
  assign xy_u_o      = cdres.coord[0];
  assign xy_v_o      = cdres.coord[1];
  assign xz_u_o      = cdres.coord[0];
  assign xz_v_o      = cdres.coord[2];
  assign yz_u_o      = cdres.coord[1];
  assign yz_v_o      = cdres.coord[2];
  assign weight_xy_o = wres.weight[2];
  assign weight_xz_o = wres.weight[1];
  assign weight_yz_o = wres.weight[0];
  assign status_o    = {cdres.zbox, wres.znorm};

endmodule

`default_nettype wire

// ===== src/tuvw_checker.sv =====
// ----------------------------------------------------------------------------
// tuvw_checker
// Port-level checks on latency and the flagged special cases.
// ----------------------------------------------------------------------------
`default_nettype none

module tuvw_checker import tuvw_pkg::*; #(
  parameter int MaxSharpness = DEF_MAX_SHARPNESS
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             done_o,
  input wire logic [OUT_W-1:0] xy_u_o,
  input wire logic [OUT_W-1:0] xy_v_o,
  input wire logic [OUT_W-1:0] xz_v_o,
  input wire logic [OUT_W-1:0] weight_xy_o,
  input wire logic [OUT_W-1:0] weight_xz_o,
  input wire logic [OUT_W-1:0] weight_yz_o,
  input wire logic [1:0]       status_o
);

  localparam int Lat = weight_latency(MaxSharpness);

  // every result traces back to an accepted input transaction
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Lat))
    else $error("result without matching input transaction");

  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Lat done_o)
    else $error("input transaction produced no result");

  a_zero_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o[1]) |->
      (xy_u_o == HALF_Q16 && xy_v_o == HALF_Q16 && xz_v_o == HALF_Q16))
    else $error("zero box must give centered coordinates");

  a_zero_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o[0]) |->
      (weight_xy_o == '0 && weight_xz_o == '0 && weight_yz_o == '0))
    else $error("zero normal must give zero weights");

endmodule

bind triplanar_uv_and_weights tuvw_checker #(
  .MaxSharpness(MAX_SHARPNESS)
) u_tuvw_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .start(start),
  .busy(busy),
  .done_o(done_o),
  .xy_u_o(xy_u_o),
  .xy_v_o(xy_v_o),
  .xz_v_o(xz_v_o),
  .weight_xy_o(weight_xy_o),
  .weight_xz_o(weight_xz_o),
  .weight_yz_o(weight_yz_o),
  .status_o(status_o)
);

`default_nettype wire

// ===== dv/triplanar_uv_and_weights_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triplanar_uv_and_weights_tb
// Self-checking bench: directed corner points, then random shading points
// under several sharpness settings and input gap patterns, each result
// compared to a table value or a cycle-free model of coords and weights.
// ----------------------------------------------------------------------------

module triplanar_uv_and_weights_tb;
  import tuvw_pkg::*;

  localparam int DRAIN_CYCLES = 52 + DEF_MAX_SHARPNESS + 8;
  localparam int N_RANDOM     = 1240;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ZNORM = 2'd1;
  localparam logic [1:0] ST_ZBOX  = 2'd2;
  localparam logic [1:0] ST_BOTH  = 2'd3;

  typedef struct packed {
    logic [2:0][31:0] lo;
    logic [2:0][31:0] hi;
    logic [2:0][31:0] pt;
    logic [2:0][15:0] nrm;
  } shade_pt_t;

  // uv: xy_u, xy_v, xz_u, xz_v, yz_u, yz_v; w: xy, xz, yz
  typedef struct packed {
    logic [5:0][OUT_W-1:0] uv;
    logic [2:0][OUT_W-1:0] w;
    logic [1:0]            st;
  } uvw_res_t;

  typedef struct packed {
    shade_pt_t pt;
    bit        chk;
    uvw_res_t  want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  shade_pt_t cur = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [SHARP_W-1:0] cfg_data_i = '0;
  logic done_o;
  logic [OUT_W-1:0] xy_u_o, xy_v_o, xz_u_o, xz_v_o, yz_u_o, yz_v_o;
  logic [OUT_W-1:0] weight_xy_o, weight_xz_o, weight_yz_o;
  logic [1:0] status_o;

  logic [SHARP_W-1:0] sharp_reg = 5'd1;
  uvw_res_t  pending_q[$];
  dir_row_t  dir_tbl[$];
  int        mismatches = 0;
  int        n_sent = 0;
  int        n_seen = 0;
  int        idle_pct = 0;

  always #5 clk_i = ~clk_i;

  triplanar_uv_and_weights u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .box_min_x_i(cur.lo[0]),
    .box_min_y_i(cur.lo[1]),
    .box_min_z_i(cur.lo[2]),
    .box_max_x_i(cur.hi[0]),
    .box_max_y_i(cur.hi[1]),
    .box_max_z_i(cur.hi[2]),
    .point_x_i  (cur.pt[0]),
    .point_y_i  (cur.pt[1]),
    .point_z_i  (cur.pt[2]),
    .normal_x_i (cur.nrm[0]),
    .normal_y_i (cur.nrm[1]),
    .normal_z_i (cur.nrm[2]),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .done_o     (done_o),
    .xy_u_o     (xy_u_o),
    .xy_v_o     (xy_v_o),
    .xz_u_o     (xz_u_o),
    .xz_v_o     (xz_v_o),
    .yz_u_o     (yz_u_o),
    .yz_v_o     (yz_v_o),
    .weight_xy_o(weight_xy_o),
    .weight_xz_o(weight_xz_o),
    .weight_yz_o(weight_yz_o),
    .status_o   (status_o)
  );

  function automatic longint unsigned mag(input longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic uvw_res_t triplanar_predict(input shade_pt_t p,
                                                 input logic [SHARP_W-1:0] sh);
    uvw_res_t r;
    longint unsigned ext[3], crd[3], a[3], q[3], pw[3];
    longint unsigned tot, rel, cen, v, m, acc, sum;
    longint lo, hi, pp;
    int s;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      lo = longint'($signed(p.lo[i]));
      hi = longint'($signed(p.hi[i]));
      ext[i] = mag(hi - lo);
      a[i] = mag(longint'($signed(p.nrm[i])));
    end
    tot = ext[0];
    if (ext[1] > tot) tot = ext[1];
    if (ext[2] > tot) tot = ext[2];
    if (tot == 0) r.st[1] = 1'b1;
    for (int i = 0; i < 3; i++) begin
      lo = longint'($signed(p.lo[i]));
      pp = longint'($signed(p.pt[i]));
      if (tot == 0) begin
        crd[i] = 32768;
      end else begin
        rel = (ext[i] * 65536) / tot;
        cen = (65536 - rel) >> 1;
        if (ext[i] == 0) begin
          crd[i] = cen;
        end else begin
          v = (mag(pp - lo) * rel) / ext[i] + cen;
          crd[i] = (v > 65536) ? 65536 : v;
        end
      end
    end
    r.uv[0] = OUT_W'(crd[0]); r.uv[1] = OUT_W'(crd[1]);
    r.uv[2] = OUT_W'(crd[0]); r.uv[3] = OUT_W'(crd[2]);
    r.uv[4] = OUT_W'(crd[1]); r.uv[5] = OUT_W'(crd[2]);

    s = (sh < 1) ? 1 : (sh > DEF_MAX_SHARPNESS) ? DEF_MAX_SHARPNESS : int'(sh);
    m = a[0];
    if (a[1] > m) m = a[1];
    if (a[2] > m) m = a[2];
    if (m == 0) begin
      r.st[0] = 1'b1;
    end else begin
      for (int i = 0; i < 3; i++) begin
        q[i] = ((a[i] << 30) + (m >> 1)) / m;
        acc = q[i];
        for (int k = 1; k < s; k++) acc = (acc * q[i] + (64'd1 << 29)) >> 30;
        pw[i] = acc;
      end
      sum = pw[0] + pw[1] + pw[2];
      // weight for a plane comes from the normal axis it faces
      r.w[0] = OUT_W'((pw[2] * 65536 + (sum >> 1)) / sum);
      r.w[1] = OUT_W'((pw[1] * 65536 + (sum >> 1)) / sum);
      r.w[2] = OUT_W'((pw[0] * 65536 + (sum >> 1)) / sum);
    end
    return r;
  endfunction

  function automatic uvw_res_t fixed_res(input logic [OUT_W-1:0] uvv,
                                         input logic [OUT_W-1:0] wxy,
                                         input logic [OUT_W-1:0] wxz,
                                         input logic [OUT_W-1:0] wyz,
                                         input logic [1:0] st);
    uvw_res_t r;
    for (int i = 0; i < 6; i++) r.uv[i] = uvv;
    r.w[0] = wxy; r.w[1] = wxz; r.w[2] = wyz;
    r.st = st;
    return r;
  endfunction

  function automatic shade_pt_t mk_pt(input logic [31:0] lo, input logic [31:0] hi,
                                      input logic [31:0] pt, input logic [15:0] nx,
                                      input logic [15:0] ny, input logic [15:0] nz);
    shade_pt_t p;
    for (int i = 0; i < 3; i++) begin
      p.lo[i] = lo; p.hi[i] = hi; p.pt[i] = pt;
    end
    p.nrm[0] = nx; p.nrm[1] = ny; p.nrm[2] = nz;
    return p;
  endfunction

  function automatic shade_pt_t rand_pt();
    shade_pt_t p;
    int unsigned sel;
    logic [31:0] c, e;
    sel = $urandom_range(9);
    for (int i = 0; i < 3; i++) begin
      if (sel < 2) begin
        p.lo[i] = $urandom; p.hi[i] = $urandom; p.pt[i] = $urandom;
        p.nrm[i] = 16'($urandom);
      end else begin
        c = $signed($urandom) >>> $urandom_range(0, 3);
        e = ($urandom_range(7) == 0) ? 32'd0 : ($urandom >> $urandom_range(1, 30));
        p.lo[i] = c;
        p.hi[i] = ($urandom_range(5) == 0) ? c - e : c + e;
        // mostly inside the box, sometimes outside it
        p.pt[i] = c + (($urandom_range(4) == 0) ? $urandom >> $urandom_range(1, 31)
                                                : ((e == 0) ? 32'd0 : $urandom % e));
        p.nrm[i] = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(0, 16384));
        if ($urandom_range(1)) p.nrm[i] = -p.nrm[i];
      end
    end
    return p;
  endfunction

  task automatic push_point(input shade_pt_t p, input bit chk, input uvw_res_t want);
    while ($urandom_range(99) < idle_pct) @(negedge clk_i) start <= 1'b0;
    @(negedge clk_i);
    start <= 1'b1;
    cur <= p;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    pending_q.push_back(chk ? want : triplanar_predict(p, sharp_reg));
    n_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i) start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_sharpness(input logic [SHARP_W-1:0] v);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    sharp_reg = v;
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  // result checker
  always @(posedge clk_i) begin
    uvw_res_t got, exp_r;
    if (rst_ni && done_o) begin
      got.uv = {yz_v_o, yz_u_o, xz_v_o, xz_u_o, xy_v_o, xy_u_o};
      got.w  = {weight_yz_o, weight_xz_o, weight_xy_o};
      got.st = status_o;
      n_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result transaction", $time);
      end else begin
        exp_r = pending_q.pop_front();
        for (int i = 0; i < 6; i++)
          if (got.uv[i] !== exp_r.uv[i]) begin
            mismatches++;
            $display("%0t: coord %0d expected %0d actual %0d", $time, i,
                     exp_r.uv[i], got.uv[i]);
          end
        for (int i = 0; i < 3; i++)
          if (got.w[i] !== exp_r.w[i]) begin
            mismatches++;
            $display("%0t: weight %0d expected %0d actual %0d", $time, i,
                     exp_r.w[i], got.w[i]);
          end
        if (got.st !== exp_r.st) begin
          mismatches++;
          $display("%0t: status expected %0d actual %0d", $time, exp_r.st, got.st);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    shade_pt_t p;
    logic [SHARP_W-1:0] sweep[5];
    dir_row_t row;
    sweep = '{5'd0, 5'd31, 5'd16, 5'd1, 5'd2};

    // corner rows carry their own expectation, the rest are predicted
    dir_tbl.push_back({mk_pt(0, 0, 0, 0, 0, 0), 1'b1,
                       fixed_res(HALF_Q16, 0, 0, 0, ST_BOTH)});
    dir_tbl.push_back({mk_pt(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 16384, 0, 0),
                       1'b1, fixed_res(ONE_Q16, 0, 0, ONE_Q16, ST_OK)});
    dir_tbl.push_back({mk_pt(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, 0, -16384),
                       1'b1, fixed_res(0, ONE_Q16, 0, 0, ST_OK)});
    dir_tbl.push_back({mk_pt(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0),
                       1'b1, fixed_res(0, 0, 0, 0, ST_ZNORM)});
    dir_tbl.push_back({mk_pt(32'h1234_5678, 32'h1234_5678, 32'hffff_0000, 0, 16384, 0),
                       1'b1, fixed_res(HALF_Q16, 0, ONE_Q16, 0, ST_ZBOX)});
    // flat x axis
    p = mk_pt(0, 32'h000a_0000, 32'h0003_0000, 5000, -9000, 12000);
    p.hi[0] = 0;
    dir_tbl.push_back({p, 1'b0, uvw_res_t'('0)});
    // point outside box
    dir_tbl.push_back({mk_pt(32'hfffe_0000, 32'h0002_0000, 32'h0050_0000, 1, 2, 3),
                       1'b0, uvw_res_t'('0)});
    // normals out of range
    dir_tbl.push_back({mk_pt(0, 32'h0001_0000, 32'h0000_8000, 16'h8000, 16'h7fff, 1),
                       1'b0, uvw_res_t'('0)});
    dir_tbl.push_back({mk_pt(0, 32'h0001_0000, 32'h0000_4000, 9459, -9459, 9459),
                       1'b0, uvw_res_t'('0)});
    // reversed box, min above max
    dir_tbl.push_back({mk_pt(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 16'h8000,
                             16'h8000, 16'h8000), 1'b0, uvw_res_t'('0)});
    p = mk_pt(32'hffff_ffff, 32'h0000_0001, 32'h0000_0000, 16'hffff, 16'h4000, 16'hc000);
    p.hi[2] = 32'h7fff_0000;
    dir_tbl.push_back({p, 1'b0, uvw_res_t'('0)});

    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    foreach (dir_tbl[i]) begin
      row = dir_tbl[i];
      push_point(row.pt, row.chk, row.want);
    end

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 8 : (ph == 1) ? 83 : 0;
      for (int c = 0; c < 4; c++) begin
        set_sharpness((ph * 4 + c < 5) ? sweep[ph * 4 + c] : 5'($urandom));
        repeat (N_RANDOM / 12) push_point(rand_pt(), 1'b0, uvw_res_t'('0));
      end
    end
    wait_drained();

    if (pending_q.size() != 0) begin
      mismatches++;
      $display("%0t: %0d results never arrived", $time, pending_q.size());
    end
    $display("covered %0d shading points, %0d results, sharpness 0..31 with idle gaps",
             n_sent, n_seen);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
